@@ hw/rtl/irnsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// irnsfd_pkg
// shared types and constants of the pulse-distance ir frame decoder
// ----------------------------------------------------------------------------
package irnsfd_pkg;

  // nominal pulse lengths, microseconds
  localparam int unsigned NOM_W = 14;
  localparam logic [NOM_W-1:0] HDR_MARK_US   = 14'd8360;
  localparam logic [NOM_W-1:0] HDR_SPACE_US  = 14'd4248;
  localparam logic [NOM_W-1:0] BIT_MARK_US   = 14'd554;
  localparam logic [NOM_W-1:0] ONE_SPACE_US  = 14'd1592;
  localparam logic [NOM_W-1:0] ZERO_SPACE_US = 14'd545;

  // tolerance register
  localparam int unsigned TOL_W = 7;
  localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;

  // scaled bound width: (100 + 127) * 8360 fits in 21 bits
  localparam int unsigned FAC_W = 8;
  localparam int unsigned Y_W   = 21;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_BIT    = 3'd2,
    ST_CHECKSUM   = 3'd3,
    ST_SHORT      = 3'd4
  } status_e;

  typedef struct packed {
    logic hdr_mark;
    logic hdr_space;
    logic bit_mark;
    logic one_space;
    logic zero_space;
  } match_t;

endpackage

@@ hw/rtl/irnsfd_match.sv @@
// ----------------------------------------------------------------------------
// irnsfd_match
// compares one pulse duration against the five nominal lengths within the
// programmed percentage tolerance, without division
// ----------------------------------------------------------------------------
module irnsfd_match import irnsfd_pkg::*; #(
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic [DURATION_BITS-1:0] dur_i,
  input  logic [TOL_W-1:0]         tol_i,
  output match_t                   match_o
);

  localparam int unsigned CMP_W    = DURATION_BITS + 7;
  localparam int unsigned PCT_FULL = 100;
  localparam int unsigned PCT_RND  = PCT_FULL - 1;

  logic [FAC_W-1:0] fac_lo;
  logic [FAC_W-1:0] fac_hi;
  logic [CMP_W-1:0] d100;

  // d >= floor(y_lo/100) <=> 100*d + 99 >= y_lo ; d <= floor(y_hi/100) <=> 100*d <= y_hi
  function automatic logic fits(input logic [CMP_W-1:0] d_s, input logic [FAC_W-1:0] f_lo,
                                input logic [FAC_W-1:0] f_hi, input logic [NOM_W-1:0] nom);
    logic [Y_W-1:0] y_lo;
    logic [Y_W-1:0] y_hi;
    y_lo = Y_W'(f_lo) * Y_W'(nom);
    y_hi = Y_W'(f_hi) * Y_W'(nom);
    return ((d_s + CMP_W'(PCT_RND)) >= CMP_W'(y_lo)) && (d_s <= CMP_W'(y_hi));
  endfunction

  always_comb begin
    fac_hi = FAC_W'(PCT_FULL) + FAC_W'(tol_i);
    if (tol_i >= TOL_W'(PCT_FULL)) begin
      fac_lo = '0;
    end else begin
      fac_lo = FAC_W'(PCT_FULL) - FAC_W'(tol_i);
    end
  end

  assign d100 = CMP_W'(dur_i) * CMP_W'(PCT_FULL);

  assign match_o.hdr_mark   = fits(d100, fac_lo, fac_hi, HDR_MARK_US);
  assign match_o.hdr_space  = fits(d100, fac_lo, fac_hi, HDR_SPACE_US);
  assign match_o.bit_mark   = fits(d100, fac_lo, fac_hi, BIT_MARK_US);
  assign match_o.one_space  = fits(d100, fac_lo, fac_hi, ONE_SPACE_US);
  assign match_o.zero_space = fits(d100, fac_lo, fac_hi, ZERO_SPACE_US);

endmodule

@@ hw/rtl/ir_nibble_sum_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// ir_nibble_sum_frame_decoder
// pulse-distance ir frame decoder with nibble-sum checksum
// ----------------------------------------------------------------------------
// channel  dir  transfer when        payload
// s_axis   in   tvalid & tready      tdata: duration_us, tuser: is_mark,
//                                    tlast: capture_end
// m_axis   out  tvalid & tready      tdata: status, data_byte, byte_index,
//                                    tlast: last
// cfg      in   cfg_valid & ready    cfg_data: tolerance_percent
//
// one pulse per cycle unless held by m_axis or the byte burst; a good frame
// drains 14 bytes from the byte store, one per cycle while m_axis is ready;
// pulses that make no result and write no byte keep flowing meanwhile
// the output register holds a result under m_axis stall, result-free pulses
// still pass; rst_ni clears control state, the byte store is not cleared
// ----------------------------------------------------------------------------
module ir_nibble_sum_frame_decoder import irnsfd_pkg::*; #(
  parameter int unsigned DATA_BYTES    = 14,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((DURATION_BITS+7)/8)*8-1:0]   s_axis_tdata,  // duration_us
  input  logic                                 s_axis_tuser,  // is_mark
  input  logic                                 s_axis_tlast,  // capture_end

  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status, data_byte, byte_index
  output logic [((STATUS_W+BYTE_W+((DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1)+7)/8)*8-1:0]
                                               m_axis_tdata,
  output logic                                 m_axis_tlast,  // last

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [TOL_W-1:0]                     cfg_data_i
);

  localparam int unsigned IN_W  = ((DURATION_BITS + 7) / 8) * 8;
  localparam int unsigned IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam int unsigned CNT_W = $clog2(DATA_BYTES + 1);
  localparam int unsigned OUT_W = ((STATUS_W + BYTE_W + IDX_W + 7) / 8) * 8;
  localparam int unsigned POS_W = 3;

  typedef enum logic [5:0] {
    PH_HMARK  = 6'b000001,
    PH_HSPACE = 6'b000010,
    PH_FMARK  = 6'b000100,
    PH_SPACE  = 6'b001000,
    PH_MARK   = 6'b010000,
    PH_IGNORE = 6'b100000
  } phase_e;

  logic [TOL_W-1:0]         tol_q;

  logic                     in_valid_q;
  logic                     in_mark_q;
  logic                     in_end_q;
  logic [DURATION_BITS-1:0] in_dur_q;

  phase_e                   phase_q, phase_d, phase_nx;
  logic [POS_W-1:0]         bitpos_q;
  logic [CNT_W-1:0]         bytecnt_q;
  logic [BYTE_W-1:0]        shift_q;
  logic [BYTE_W-1:0]        sum_q;
  logic [BYTE_W-1:0]        store_q [DATA_BYTES];

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [BYTE_W-1:0]        out_byte_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic                     out_last_q;
  logic                     burst_q;
  logic [IDX_W-1:0]         burst_idx_q;

  match_t                   match;
  status_e                  err_code;
  logic                     err;
  logic                     done;
  logic                     set_bit;
  logic                     clear_frame;
  logic                     adv_bit;
  logic                     store_we;
  logic                     short_end;
  logic                     single;
  logic                     produces;
  logic                     out_free;
  logic                     proc;
  logic                     s_fire;

  logic                     out_load;
  status_e                  out_status_d;
  logic [BYTE_W-1:0]        out_byte_d;
  logic [IDX_W-1:0]         out_idx_d;
  logic                     out_last_d;
  logic                     burst_end;

  irnsfd_match #(
    .DURATION_BITS (DURATION_BITS)
  ) u_match (
    .dur_i   (in_dur_q),
    .tol_i   (tol_q),
    .match_o (match)
  );

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // decode
  always_comb begin
    phase_nx    = phase_q;
    err         = 1'b0;
    err_code    = ST_OK;
    done        = 1'b0;
    set_bit     = 1'b0;
    clear_frame = 1'b0;
    adv_bit     = 1'b0;
    store_we    = 1'b0;
    unique case (phase_q)
      PH_HMARK: begin
        if (in_mark_q && match.hdr_mark) begin
          phase_nx = PH_HSPACE;
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_HEADER;
        end
      end
      PH_HSPACE: begin
        if (!in_mark_q && match.hdr_space) begin
          phase_nx = PH_FMARK;
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_HEADER;
        end
      end
      PH_FMARK: begin
        if (in_mark_q && match.bit_mark) begin
          phase_nx    = PH_SPACE;
          clear_frame = 1'b1;
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_HEADER;
        end
      end
      PH_SPACE: begin
        if (!in_mark_q && match.one_space) begin
          set_bit  = 1'b1;
          phase_nx = PH_MARK;
        end else if (!in_mark_q && match.zero_space) begin
          phase_nx = PH_MARK;
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_BIT;
        end
      end
      PH_MARK: begin
        if (in_mark_q && match.bit_mark) begin
          adv_bit  = 1'b1;
          phase_nx = PH_SPACE;
          if (bitpos_q == '1) begin
            if (bytecnt_q < CNT_W'(DATA_BYTES)) begin
              store_we = 1'b1;
            end else begin
              if (sum_q == shift_q) begin
                done = 1'b1;
              end else begin
                err      = 1'b1;
                err_code = ST_CHECKSUM;
              end
              phase_nx = PH_IGNORE;
            end
          end
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_BIT;
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase
    if (err) begin
      phase_nx = PH_IGNORE;
    end
    short_end = in_end_q && !err && !done && (phase_nx != PH_HMARK) && (phase_nx != PH_IGNORE);
    phase_d   = in_end_q ? PH_HMARK : phase_nx;
  end

  assign single   = err || short_end;
  assign produces = single || done;
  assign out_free = !out_valid_q || m_axis_tready;
  assign proc     = in_valid_q
                    && (!produces || (!burst_q && out_free))
                    && !(burst_q && store_we);

  // input register
  assign s_axis_tready = !in_valid_q || proc;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_mark_q <= s_axis_tuser;
      in_end_q  <= s_axis_tlast;
      in_dur_q  <= s_axis_tdata[DURATION_BITS-1:0];
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HMARK;
      bitpos_q  <= '0;
      bytecnt_q <= '0;
      shift_q   <= '0;
      sum_q     <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      if (clear_frame) begin
        bitpos_q  <= '0;
        bytecnt_q <= '0;
        shift_q   <= '0;
        sum_q     <= '0;
      end else begin
        if (adv_bit) begin
          bitpos_q <= bitpos_q + POS_W'(1);
        end
        if (set_bit) begin
          shift_q <= shift_q | (BYTE_W'(1) << bitpos_q);
        end else if (store_we) begin
          shift_q   <= '0;
          sum_q     <= sum_q + BYTE_W'(shift_q[BYTE_W-1:NIBBLE_W])
                             + BYTE_W'(shift_q[NIBBLE_W-1:0]);
          bytecnt_q <= bytecnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && store_we) begin
      store_q[bytecnt_q[IDX_W-1:0]] <= shift_q;
    end
  end

  // result register and byte burst
  always_comb begin
    out_load     = 1'b0;
    out_status_d = ST_OK;
    out_byte_d   = '0;
    out_idx_d    = '0;
    out_last_d   = 1'b1;
    burst_end    = 1'b0;
    if (proc && single) begin
      out_load     = 1'b1;
      out_status_d = err ? err_code : ST_SHORT;
    end else if (proc && done) begin
      out_load   = 1'b1;
      out_byte_d = store_q[0];
      out_last_d = (DATA_BYTES == 1);
    end else if (burst_q && out_free) begin
      out_load   = 1'b1;
      out_byte_d = store_q[burst_idx_q];
      out_idx_d  = burst_idx_q;
      burst_end  = (burst_idx_q == IDX_W'(DATA_BYTES - 1));
      out_last_d = burst_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_q     <= 1'b0;
      burst_idx_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (proc && done) begin
        burst_q     <= (DATA_BYTES > 1);
        burst_idx_q <= IDX_W'(1);
      end else if (burst_q && out_free) begin
        burst_idx_q <= burst_idx_q + IDX_W'(1);
        if (burst_end) begin
          burst_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_byte_q   <= out_byte_d;
      out_idx_q    <= out_idx_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_idx_q, out_byte_q, out_status_q});
  assign m_axis_tlast  = out_last_q;

  // checks
  a_burst_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_q && proc) |-> !produces)
    else $error("result made while byte burst drains");

  a_burst_no_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !(proc && store_we))
    else $error("byte store written while byte burst drains");

  a_done_first_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && done) |=> (out_valid_q && out_idx_q == '0 && out_status_q == ST_OK))
    else $error("frame burst does not start at byte zero");

  a_error_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> out_last_q)
    else $error("error status not flagged last");

endmodule

@@ dv/ir_frame_decode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_frame_decode_checker
// watches the pulse, result and tolerance channels of the ir frame decoder,
// decodes every pulse transfer on its own copy of the decoder state and
// compares each result transfer, field by field, with the oldest expected one
// ----------------------------------------------------------------------------
module ir_frame_decode_checker import irnsfd_pkg::*; #(
  parameter int unsigned NBYTES = 14,
  parameter int unsigned IN_W   = 16,
  parameter int unsigned OUT_W  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pulse_valid_i,
  input  logic              pulse_ready_i,
  input  logic [IN_W-1:0]   pulse_data_i,   // duration_us
  input  logic              pulse_user_i,   // is_mark
  input  logic              pulse_last_i,   // capture_end
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [OUT_W-1:0]  res_data_i,     // status, data_byte, byte_index
  input  logic              res_last_i,     // last
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [TOL_W-1:0]  cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned IDX_W      = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam int unsigned REPORT_MAX = 50;

  typedef enum logic [2:0] {
    PH_HDR_MARK,
    PH_HDR_SPACE,
    PH_FIRST_MARK,
    PH_BIT_SPACE,
    PH_BIT_MARK,
    PH_IGNORE
  } dec_phase_e;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  index;
    logic              last;
  } decoded_result_t;

  logic [TOL_W-1:0]  tolerance_pct;
  dec_phase_e        phase;
  logic [2:0]        bit_pos;
  int unsigned       byte_cnt;
  logic [BYTE_W-1:0] shift_reg;
  logic [BYTE_W-1:0] nibble_sum;
  logic [BYTE_W-1:0] frame_store [NBYTES];
  decoded_result_t   pending_results [$];
  int unsigned       fail_total = 0;

  function automatic bit in_window(input logic [IN_W-1:0] dur, input int unsigned nom);
    int unsigned t, lo, hi;
    t  = tolerance_pct;
    lo = (t >= 100) ? 0 : ((100 - t) * nom) / 100;
    hi = ((100 + t) * nom) / 100;
    return dur >= lo && dur <= hi;
  endfunction

  function automatic void queue_result(input status_e st, input logic [BYTE_W-1:0] data,
                                       input logic [IDX_W-1:0] index, input logic last);
    decoded_result_t r;
    r.status = st;
    r.data   = data;
    r.index  = index;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  function automatic void decode_pulse(input logic mark, input logic [IN_W-1:0] dur,
                                       input logic fin);
    status_e err;
    logic    done;
    err  = ST_OK;
    done = 1'b0;
    case (phase)
      PH_HDR_MARK: begin
        if (mark && in_window(dur, HDR_MARK_US)) phase = PH_HDR_SPACE;
        else err = ST_BAD_HEADER;
      end
      PH_HDR_SPACE: begin
        if (!mark && in_window(dur, HDR_SPACE_US)) phase = PH_FIRST_MARK;
        else err = ST_BAD_HEADER;
      end
      PH_FIRST_MARK: begin
        if (mark && in_window(dur, BIT_MARK_US)) begin
          phase      = PH_BIT_SPACE;
          bit_pos    = '0;
          byte_cnt   = 0;
          shift_reg  = '0;
          nibble_sum = '0;
        end else begin
          err = ST_BAD_HEADER;
        end
      end
      PH_BIT_SPACE: begin
        // a space inside both windows decodes as one
        if (!mark && in_window(dur, ONE_SPACE_US)) begin
          shift_reg[bit_pos] = 1'b1;
          phase = PH_BIT_MARK;
        end else if (!mark && in_window(dur, ZERO_SPACE_US)) begin
          phase = PH_BIT_MARK;
        end else begin
          err = ST_BAD_BIT;
        end
      end
      PH_BIT_MARK: begin
        if (mark && in_window(dur, BIT_MARK_US)) begin
          bit_pos = bit_pos + 3'd1;
          phase   = PH_BIT_SPACE;
          if (bit_pos == 3'd0) begin
            if (byte_cnt < NBYTES) begin
              frame_store[byte_cnt] = shift_reg;
              nibble_sum = nibble_sum + shift_reg[7:4] + shift_reg[3:0];
              byte_cnt++;
              shift_reg = '0;
            end else begin
              if (nibble_sum == shift_reg) done = 1'b1;
              else err = ST_CHECKSUM;
              phase = PH_IGNORE;
            end
          end
        end else begin
          err = ST_BAD_BIT;
        end
      end
      default: ;
    endcase

    if (err != ST_OK) begin
      queue_result(err, '0, '0, 1'b1);
      phase = PH_IGNORE;
    end else if (done) begin
      for (int i = 0; i < NBYTES; i++)
        queue_result(ST_OK, frame_store[i], IDX_W'(i), i == NBYTES - 1);
    end else if (fin && phase != PH_HDR_MARK && phase != PH_IGNORE) begin
      queue_result(ST_SHORT, '0, '0, 1'b1);
    end
    if (fin) phase = PH_HDR_MARK;
  endfunction

  function automatic void field_check(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_total++;
      if (fail_total <= REPORT_MAX)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    decoded_result_t want;
    if (pending_results.size() == 0) begin
      fail_total++;
      if (fail_total <= REPORT_MAX)
        $display("%0t ns: result transfer, expected none, actual status %0d byte %0d idx %0d",
                 $time, res_data_i[STATUS_W-1:0], res_data_i[STATUS_W +: BYTE_W],
                 res_data_i[STATUS_W+BYTE_W +: IDX_W]);
      return;
    end
    want = pending_results.pop_front();
    field_check("status", want.status, res_data_i[STATUS_W-1:0]);
    field_check("data_byte", want.data, res_data_i[STATUS_W +: BYTE_W]);
    field_check("byte_index", want.index, res_data_i[STATUS_W+BYTE_W +: IDX_W]);
    field_check("last", want.last, res_last_i);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_pct = TOL_RESET;
      phase         = PH_HDR_MARK;
      bit_pos       = '0;
      byte_cnt      = 0;
      shift_reg     = '0;
      nibble_sum    = '0;
      pending_results.delete();
      fail_count_o <= fail_total;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) tolerance_pct = cfg_data_i;
      if (pulse_valid_i && pulse_ready_i) decode_pulse(pulse_user_i, pulse_data_i, pulse_last_i);
      if (res_valid_i && res_ready_i) check_result();
      fail_count_o <= fail_total;
      pending_o    <= pending_results.size();
    end
  end

endmodule

@@ dv/ir_nibble_sum_frame_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_nibble_sum_frame_decoder_test
// drives captured ir pulses into the frame decoder: a directed set of header,
// bit timing, tolerance edge and early end cases, then random captures made
// mostly of well-formed frames and frame prefixes, some broken or noisy, under
// several tolerance settings, with random gaps and stalls on both streams;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module ir_nibble_sum_frame_decoder_test;
  import irnsfd_pkg::*;

  localparam int unsigned NBYTES        = 14;
  localparam int unsigned IN_W          = 16;
  localparam int unsigned OUT_W         = 16;
  localparam int unsigned FRAME_PULSES  = 3 + 2 * 8 * (NBYTES + 1);
  localparam int unsigned ITEM_TARGET   = 360;
  localparam int unsigned MIN_FRAMES    = 3;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  typedef enum int unsigned {
    CAP_FULL,
    CAP_CUT,
    CAP_BROKEN,
    CAP_NOISE
  } capture_e;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // duration_us
  logic              s_axis_tuser;   // is_mark
  logic              s_axis_tlast;   // capture_end
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;   // status, data_byte, byte_index
  logic              m_axis_tlast;   // last
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [TOL_W-1:0]  cfg_data_i;

  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_count = 0;
  int unsigned       tol_now;
  int unsigned       n_items = 0;
  int unsigned       n_frames = 0;
  bit                s_burst = 1'b0;
  logic [7:0]        frame_bytes [NBYTES + 1];

  ir_nibble_sum_frame_decoder #(
    .DATA_BYTES    (NBYTES),
    .DURATION_BITS (IN_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  ir_frame_decode_checker #(
    .NBYTES (NBYTES),
    .IN_W   (IN_W),
    .OUT_W  (OUT_W)
  ) decode_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pulse_valid_i (s_axis_tvalid),
    .pulse_ready_i (s_axis_tready),
    .pulse_data_i  (s_axis_tdata),
    .pulse_user_i  (s_axis_tuser),
    .pulse_last_i  (s_axis_tlast),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .res_last_i    (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, with stretches of none
  initial begin
    int unsigned stall;
    int unsigned run_left;
    bit          m_burst;
    run_left = 0;
    m_burst  = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (run_left == 0) begin
        m_burst  = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      stall = m_burst ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic int unsigned tol_edge(input int unsigned nom, input bit upper);
    if (upper) return ((100 + tol_now) * nom) / 100;
    return (tol_now >= 100) ? 0 : ((100 - tol_now) * nom) / 100;
  endfunction

  function automatic int unsigned pulse_len(input int unsigned nom);
    int unsigned lo, hi;
    lo = tol_edge(nom, 1'b0);
    hi = tol_edge(nom, 1'b1);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic void make_frame(input bit good_sum);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < NBYTES; i++) begin
      frame_bytes[i] = $urandom_range(0, 255);
      sum = sum + frame_bytes[i][7:4] + frame_bytes[i][3:0];
    end
    frame_bytes[NBYTES] = good_sum ? sum : sum ^ 8'($urandom_range(1, 255));
  endfunction

  // nominal pulse k of a frame: header mark, header space, bit mark, then
  // space and mark per bit, lsb first
  function automatic void frame_pulse(input int unsigned k, output logic mark,
                                      output int unsigned nom);
    int unsigned j;
    j = (k - 3) / 2;
    if (k == 0) begin
      mark = 1'b1;
      nom  = HDR_MARK_US;
    end else if (k == 1) begin
      mark = 1'b0;
      nom  = HDR_SPACE_US;
    end else if (k % 2 == 0) begin
      mark = 1'b1;
      nom  = BIT_MARK_US;
    end else begin
      mark = 1'b0;
      nom  = frame_bytes[j / 8][j % 8] ? ONE_SPACE_US : ZERO_SPACE_US;
    end
  endfunction

  task automatic send_pulse(input logic mark, input int unsigned dur, input logic fin,
                            input bit counted);
    int unsigned gap;
    gap = s_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dur[IN_W-1:0];
    s_axis_tuser  <= mark;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counted) n_items++;
  endtask

  task automatic send_noise(input int unsigned count, input bit counted);
    int unsigned dur;
    logic        mark;
    for (int unsigned i = 0; i < count; i++) begin
      mark = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
        0: dur = pulse_len(HDR_MARK_US);
        1: dur = pulse_len(HDR_SPACE_US);
        2: dur = pulse_len(BIT_MARK_US);
        3: dur = pulse_len(ONE_SPACE_US);
        default: dur = $urandom_range(0, 65535);
      endcase
      send_pulse(mark, dur, i == count - 1, counted);
    end
  endtask

  task automatic run_capture(input capture_e kind, input bit good_sum);
    int unsigned len, tail, dur, nom;
    logic        mark;
    s_burst = ($urandom_range(0, 3) == 0);
    make_frame(good_sum);
    tail = $urandom_range(0, 3);
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, FRAME_PULSES - 1)
                                       : $urandom_range(1, 30);
    case (kind)
      CAP_FULL: begin
        for (int unsigned k = 0; k < FRAME_PULSES; k++) begin
          frame_pulse(k, mark, nom);
          send_pulse(mark, pulse_len(nom), k == FRAME_PULSES - 1 && tail == 0, 1'b1);
        end
        send_noise(tail, 1'b0);
        n_frames++;
      end
      CAP_CUT: begin
        for (int unsigned k = 0; k < len; k++) begin
          frame_pulse(k, mark, nom);
          send_pulse(mark, pulse_len(nom), k == len - 1, 1'b1);
        end
      end
      CAP_BROKEN: begin
        len = len - 1;
        for (int unsigned k = 0; k < len; k++) begin
          frame_pulse(k, mark, nom);
          send_pulse(mark, pulse_len(nom), 1'b0, 1'b1);
        end
        frame_pulse(len, mark, nom);
        case ($urandom_range(0, 3))
          0: begin
            mark = !mark;
            dur  = pulse_len(nom);
          end
          1: dur = tol_edge(nom, 1'b1) + $urandom_range(1, 300);
          2: dur = (tol_edge(nom, 1'b0) > 0) ? tol_edge(nom, 1'b0) - 1 : tol_edge(nom, 1'b1) + 1;
          default: begin
            mark = $urandom_range(0, 1);
            dur  = $urandom_range(0, 65535);
          end
        endcase
        send_pulse(mark, dur, tail == 0, 1'b1);
        send_noise(tail, 1'b0);
      end
      default: send_noise($urandom_range(1, 6), 1'b1);
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input int unsigned t);
    tol_now = t;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= t[TOL_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned caps;
    int unsigned sched;
    int unsigned r;
    capture_e    kind;
    bit          good_sum;
    caps  = 0;
    sched = 0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    tol_now = TOL_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tolerance: short frame, header and bit errors, window edges
    send_pulse(1'b1, 8360, 1'b0, 1'b1);
    send_pulse(1'b0, 4248, 1'b0, 1'b1);
    send_pulse(1'b1, 554, 1'b0, 1'b1);
    send_pulse(1'b0, 1592, 1'b0, 1'b1);
    send_pulse(1'b1, 554, 1'b0, 1'b1);
    send_pulse(1'b0, 545, 1'b0, 1'b1);
    send_pulse(1'b1, 554, 1'b1, 1'b1);
    send_pulse(1'b0, 0, 1'b0, 1'b1);
    send_pulse(1'b1, 65535, 1'b1, 1'b1);
    send_pulse(1'b1, 6270, 1'b0, 1'b1);
    send_pulse(1'b0, 5310, 1'b0, 1'b1);
    send_pulse(1'b1, 693, 1'b1, 1'b1);
    send_pulse(1'b1, 6269, 1'b1, 1'b1);
    send_pulse(1'b1, 8360, 1'b0, 1'b1);
    send_pulse(1'b0, 4248, 1'b0, 1'b1);
    send_pulse(1'b1, 554, 1'b0, 1'b1);
    send_pulse(1'b1, 554, 1'b1, 1'b1);
    send_pulse(1'b1, 8360, 1'b0, 1'b1);
    send_pulse(1'b0, 4248, 1'b0, 1'b1);
    send_pulse(1'b1, 554, 1'b0, 1'b1);
    send_pulse(1'b0, 545, 1'b0, 1'b1);
    send_pulse(1'b0, 2000, 1'b1, 1'b1);
    send_pulse(1'b1, 65535, 1'b1, 1'b1);

    // tolerance above 100: lower window edge at zero
    wait_idle();
    write_tolerance(127);
    send_pulse(1'b1, 0, 1'b0, 1'b1);
    send_pulse(1'b0, 9642, 1'b1, 1'b1);

    wait_idle();
    write_tolerance(0);
    while (n_items < ITEM_TARGET || n_frames < MIN_FRAMES) begin
      r = $urandom_range(0, 9);
      if (caps < 2) kind = CAP_FULL;
      else if (r < 2) kind = CAP_FULL;
      else if (r < 5) kind = CAP_CUT;
      else if (r < 8) kind = CAP_BROKEN;
      else kind = CAP_NOISE;
      if (caps == 0) good_sum = 1'b1;
      else if (caps == 1) good_sum = 1'b0;
      else good_sum = ($urandom_range(0, 3) != 0);
      run_capture(kind, good_sum);
      caps++;
      if (caps % 5 == 0) begin
        wait_idle();
        case (sched % 5)
          0: write_tolerance(100);
          1: write_tolerance(127);
          2: write_tolerance($urandom_range(0, 127));
          3: write_tolerance($urandom_range(1, 48));
          default: write_tolerance(0);
        endcase
        sched++;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
